// File: hw/rtl/swm_pkg.sv
// ----------------------------------------------------------------------------
// swm_pkg: shared types and constants for the sliding window mean
// Widths of the sample store, running sum and serial divider, plus the
// request/response bundles passed between the control and its units.
// ----------------------------------------------------------------------------
package swm_pkg;

  localparam int MAX_WINDOW = 32;                    // store depth
  localparam int SAMPLE_W   = 16;                    // sample and mean width
  localparam int CFG_W      = 6;                     // window_len register width
  localparam int IDX_W      = $clog2(MAX_WINDOW);    // store address width
  localparam int CNT_W      = IDX_W + 1;             // holds 0..MAX_WINDOW
  localparam int SUM_W      = SAMPLE_W + IDX_W;      // exact window sum, signed
  localparam int DCNT_W     = $clog2(SUM_W + 1);     // divider step counter

  localparam logic [CFG_W-1:0] WINDOW_LEN_RST = CFG_W'(20);

  typedef struct packed {
    logic                en;
    logic [IDX_W-1:0]    addr;
    logic [SAMPLE_W-1:0] data;
  } store_wr_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } store_rd_t;

  typedef struct packed {
    logic                    start;
    logic signed [SUM_W-1:0] dividend;
    logic [CNT_W-1:0]        divisor;
  } div_req_t;

  typedef struct packed {
    logic                       done;
    logic signed [SAMPLE_W-1:0] quotient;
  } div_rsp_t;

endpackage

// File: hw/rtl/swm_store.sv
// ----------------------------------------------------------------------------
// swm_store: sample ring store
// One write and one registered read port; per-entry valid bits make entries
// read as zero until first written after reset.
// ----------------------------------------------------------------------------
module swm_store (
  input  logic                              clk,
  input  logic                              rst,
  input  swm_pkg::store_wr_t                wr,
  input  swm_pkg::store_rd_t                rd,
  output logic signed [swm_pkg::SAMPLE_W-1:0] rd_data
);

  logic [swm_pkg::SAMPLE_W-1:0]   mem [swm_pkg::MAX_WINDOW];
  logic [swm_pkg::MAX_WINDOW-1:0] valid;
  logic [swm_pkg::SAMPLE_W-1:0]   rd_q;
  logic                           rd_vld;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd.en) begin
      rd_q <= mem[rd.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr.en) begin
        valid[wr.addr] <= 1'b1;
      end
      if (rd.en) begin
        rd_vld <= valid[rd.addr];
      end
    end
  end

  assign rd_data = rd_vld ? $signed(rd_q) : '0;

endmodule

// File: hw/rtl/swm_div.sv
// ----------------------------------------------------------------------------
// swm_div: bit-serial signed divider
// Restoring division of the window sum by the window length, one quotient
// bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module swm_div (
  input  logic              clk,
  input  logic              rst,
  input  swm_pkg::div_req_t req,
  output swm_pkg::div_rsp_t rsp
);

  typedef enum logic [1:0] {
    IDLE,
    RUN,
    DONE
  } state_t;

  state_t                        state;
  logic [swm_pkg::SUM_W-1:0]     qreg;     // dividend bits out, quotient bits in
  logic [swm_pkg::CNT_W-1:0]     rem;
  logic [swm_pkg::CNT_W-1:0]     dvsr;
  logic                          neg;
  logic [swm_pkg::DCNT_W-1:0]    cnt;

  logic [swm_pkg::CNT_W:0]       rem_sh;
  logic [swm_pkg::CNT_W:0]       rem_sub;
  logic                          qbit;
  logic [swm_pkg::SUM_W-1:0]     qsigned;

  always_comb begin
    rem_sh  = {rem, qreg[swm_pkg::SUM_W-1]};
    rem_sub = rem_sh - {1'b0, dvsr};
    qbit    = (rem_sh >= {1'b0, dvsr});
    qsigned = neg ? (~qreg + 1'b1) : qreg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      unique case (state)
        IDLE: begin
          if (req.start) begin
            neg   <= req.dividend[swm_pkg::SUM_W-1];
            qreg  <= req.dividend[swm_pkg::SUM_W-1] ? (~req.dividend + 1'b1)
                                                    : req.dividend;
            dvsr  <= req.divisor;
            rem   <= '0;
            cnt   <= '0;
            state <= RUN;
          end
        end
        RUN: begin
          rem  <= qbit ? rem_sub[swm_pkg::CNT_W-1:0] : rem_sh[swm_pkg::CNT_W-1:0];
          qreg <= {qreg[swm_pkg::SUM_W-2:0], qbit};
          cnt  <= cnt + 1'b1;
          if (cnt == swm_pkg::DCNT_W'(swm_pkg::SUM_W - 1)) begin
            state <= DONE;
          end
        end
        DONE: begin
          state <= IDLE;
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  assign rsp.done     = (state == DONE);
  assign rsp.quotient = $signed(qsigned[swm_pkg::SAMPLE_W-1:0]);

endmodule

// File: hw/rtl/sliding_window_mean.sv
// ----------------------------------------------------------------------------
// sliding_window_mean: moving-average filter over a ring of 16-bit samples
// Each sample beat is written into the ring; once the window has wrapped,
// the ring is summed entry by entry and divided by the window length.
// ----------------------------------------------------------------------------
//
//  channel  handshake              payload
//  -------  ---------------------  -------------------------------
//  cfg      cfg_valid / cfg_ready  cfg_data   (window_len, 6 bit)
//  in       in_valid  / in_ready   sample     (signed 16 bit)
//  out      out_valid / out_ready  mean (signed 16), window_full
//
//  Until the window first fills, a beat is accepted and then loaded into the
//  output register. After that, with L = window_len (0 read as 1, >32 read
//  as 32): one-entry-per-cycle summing read of the L ring entries, bit-serial
//  divider (21 quotient bits), output load, then back to idle.
//  One sample is processed at a time; in_ready returns once the result sits
//  in the output register, so the next beat overlaps an unread result.
//  Synchronous active-high reset clears the ring (valid bits), index, filled
//  flag, window_len (to 20) and the output valid flag. cfg_ready is always high.
// ----------------------------------------------------------------------------
module sliding_window_mean (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [swm_pkg::CFG_W-1:0]             cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [swm_pkg::SAMPLE_W-1:0]   sample,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [swm_pkg::SAMPLE_W-1:0]   mean,
  output logic                                  window_full
);

  typedef enum logic [1:0] {
    IDLE,   // waiting for a sample beat
    SUM,    // reading ring entries 0..len-1 into the accumulator
    DIV,    // waiting on the serial divider
    FIN     // result ready, waiting for the output register
  } state_t;

  state_t                               state;
  logic [swm_pkg::CFG_W-1:0]            window_len;
  logic [swm_pkg::IDX_W-1:0]            wr_idx;
  logic                                 filled;
  logic [swm_pkg::CNT_W-1:0]            len_q;     // length latched per beat
  logic [swm_pkg::CNT_W-1:0]            rd_cnt;
  logic                                 pend;      // read issued last cycle
  logic signed [swm_pkg::SUM_W-1:0]     acc;       // running window sum
  logic signed [swm_pkg::SAMPLE_W-1:0]  res_mean;

  logic [swm_pkg::CNT_W-1:0]            eff_len;
  logic [swm_pkg::CNT_W-1:0]            idx_next;
  logic                                 wrap;
  logic                                 in_acc;
  logic                                 issue;
  logic                                 load_out;  // result moves to output reg
  logic signed [swm_pkg::SAMPLE_W-1:0]  rd_data;

  swm_pkg::store_wr_t                   st_wr;
  swm_pkg::store_rd_t                   st_rd;
  swm_pkg::div_req_t                    dreq;
  swm_pkg::div_rsp_t                    drsp;

  // Zero acts as a length of one; anything past the ring depth is clamped.
  always_comb begin
    if (window_len == '0) begin
      eff_len = swm_pkg::CNT_W'(1);
    end else if ((swm_pkg::CFG_W + 1)'(window_len) >
                 (swm_pkg::CFG_W + 1)'(swm_pkg::MAX_WINDOW)) begin
      eff_len = swm_pkg::CNT_W'(swm_pkg::MAX_WINDOW);
    end else begin
      eff_len = swm_pkg::CNT_W'(window_len);
    end
  end

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == IDLE);
  assign in_acc    = in_valid && in_ready;

  // Index advance; a shrunk window also forces the wrap.
  assign idx_next = swm_pkg::CNT_W'(wr_idx) + 1'b1;
  assign wrap     = (idx_next >= eff_len);

  assign st_wr.en   = in_acc;
  assign st_wr.addr = wr_idx;
  assign st_wr.data = sample;

  assign issue      = (state == SUM) && (rd_cnt != len_q);
  assign st_rd.en   = issue;
  assign st_rd.addr = rd_cnt[swm_pkg::IDX_W-1:0];

  assign dreq.start    = (state == SUM) && (rd_cnt == len_q) && !pend;
  assign dreq.dividend = acc;
  assign dreq.divisor  = len_q;

  // Output register takes the result when empty or being drained this cycle
  assign load_out = (state == FIN) && (!out_valid || out_ready);

  swm_store u_store (
    .clk     (clk),
    .rst     (rst),
    .wr      (st_wr),
    .rd      (st_rd),
    .rd_data (rd_data)
  );

  swm_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      window_len <= swm_pkg::WINDOW_LEN_RST;
      wr_idx     <= '0;
      filled     <= 1'b0;
      pend       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        window_len <= cfg_data;
      end

      out_valid <= load_out || (out_valid && !out_ready);

      pend <= issue;

      unique case (state)
        IDLE: begin
          if (in_acc) begin
            len_q  <= eff_len;
            rd_cnt <= '0;
            acc    <= '0;
            if (wrap) begin
              wr_idx <= '0;
              filled <= 1'b1;
              state  <= SUM;
            end else begin
              wr_idx   <= idx_next[swm_pkg::IDX_W-1:0];
              res_mean <= '0;
              state    <= filled ? SUM : FIN;
            end
          end
        end
        SUM: begin
          if (issue) begin
            rd_cnt <= rd_cnt + 1'b1;
          end
          if (pend) begin
            acc <= acc + swm_pkg::SUM_W'(rd_data);
          end
          if (dreq.start) begin
            state <= DIV;
          end
        end
        DIV: begin
          if (drsp.done) begin
            res_mean <= drsp.quotient;
            state    <= FIN;
          end
        end
        FIN: begin
          if (load_out) begin
            mean        <= res_mean;
            window_full <= filled;
            state       <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule
